// File: hdl/assert_macros.svh
// Assertion helpers for the prime sum checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define PSUM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("prime sum assertion failed");

// Same check, but also held during reset.
`define PSUM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("prime sum assertion failed");

`endif

// File: hdl/psum_pkg.sv
`timescale 1ns / 1ps

package psum_pkg;

   localparam int LIMIT_BITS = 16;
   localparam int SUM_BITS   = 28;
   localparam int PTR_BITS   = LIMIT_BITS + 1;
   localparam int DEPTH      = 1 << LIMIT_BITS;
   localparam int ACC_BITS   = ((SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS) + 1;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   typedef logic [LIMIT_BITS-1:0] addr_type;
   typedef logic [SUM_BITS-1:0]   sum_type;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      logic     wdata;
      addr_type raddr;
   } mem_req_type;

   typedef struct packed {
      logic    idle;
      logic    done;
      sum_type sum;
   } status_type;

endpackage

// File: hdl/psum_ram.sv
`timescale 1ns / 1ps

module psum_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/psum_ctrl.sv
`timescale 1ns / 1ps

module psum_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  psum_pkg::addr_type       limit,
   input  logic                     take,
   input  logic                     rdata,
   output psum_pkg::mem_req_type    mem_req,
   output psum_pkg::status_type     status
);

   localparam int PB = psum_pkg::PTR_BITS;
   localparam int LB = psum_pkg::LIMIT_BITS;
   localparam int AB = psum_pkg::ACC_BITS;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_SQCHK  = 4'd2;
   localparam logic [3:0] ST_READ   = 4'd3;
   localparam logic [3:0] ST_TEST   = 4'd4;
   localparam logic [3:0] ST_MARK   = 4'd5;
   localparam logic [3:0] ST_SUM    = 4'd6;
   localparam logic [3:0] ST_SUMEND = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   localparam logic [PB-1:0] LAST_ENTRY = PB'(psum_pkg::DEPTH - 1);

   logic [3:0]              state_ff, state_in;
   logic [PB-1:0]           limit_ff, limit_in;
   logic [PB-1:0]           p_ff, p_in;
   logic [PB-1:0]           sq_ff, sq_in;
   logic [PB-1:0]           m_ff, m_in;
   logic [PB-1:0]           c_ff, c_in;
   logic                    pipe_vld_ff, pipe_vld_in;
   psum_pkg::addr_type      pipe_addr_ff, pipe_addr_in;
   psum_pkg::sum_type       sum_ff, sum_in;
   logic [AB-1:0]           acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         pipe_vld_ff <= 1'b0;
         c_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= pipe_vld_in;
         c_ff        <= c_in;
      end
      limit_ff     <= limit_in;
      p_ff         <= p_in;
      sq_ff        <= sq_in;
      m_ff         <= m_in;
      pipe_addr_ff <= pipe_addr_in;
      sum_ff       <= sum_in;
   end

   assign acc = AB'(sum_ff) + AB'(pipe_addr_ff);

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      m_in         = m_ff;
      c_in         = c_ff;
      pipe_vld_in  = 1'b0;
      pipe_addr_in = pipe_addr_ff;
      sum_in       = sum_ff;
      mem_req      = '0;
      mem_req.raddr = p_ff[LB-1:0];

      // sum pass: data for the previous read, then clear that entry
      if (pipe_vld_ff) begin
         mem_req.we    = 1'b1;
         mem_req.waddr = pipe_addr_ff;
         mem_req.wdata = 1'b0;
         if (!rdata) begin
            if (acc >= AB'(psum_pkg::SUM_MAX)) begin
               sum_in = psum_pkg::SUM_MAX;
            end else begin
               sum_in = acc[psum_pkg::SUM_BITS-1:0];
            end
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = c_ff[LB-1:0];
            mem_req.wdata = 1'b0;
            c_in = c_ff + PB'(1);
            if (c_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               limit_in = {1'b0, limit};
               p_in     = PB'(2);
               sq_in    = PB'(4);
               sum_in   = '0;
               state_in = ST_SQCHK;
            end
         end
         ST_SQCHK: begin
            if (sq_ff > limit_ff) begin
               c_in     = PB'(2);
               state_in = ST_SUM;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!rdata) begin
               m_in     = sq_ff;
               state_in = ST_MARK;
            end else begin
               p_in     = p_ff + PB'(1);
               sq_in    = sq_ff + {p_ff[PB-2:0], 1'b1};
               state_in = ST_SQCHK;
            end
         end
         ST_MARK: begin
            if (m_ff <= limit_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = m_ff[LB-1:0];
               mem_req.wdata = 1'b1;
               m_in = m_ff + p_ff;
            end else begin
               p_in     = p_ff + PB'(1);
               sq_in    = sq_ff + {p_ff[PB-2:0], 1'b1};
               state_in = ST_SQCHK;
            end
         end
         ST_SUM: begin
            mem_req.raddr = c_ff[LB-1:0];
            if (c_ff <= limit_ff) begin
               pipe_vld_in  = 1'b1;
               pipe_addr_in = c_ff[LB-1:0];
               c_in         = c_ff + PB'(1);
            end else begin
               state_in = ST_SUMEND;
            end
         end
         ST_SUMEND: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign status.sum  = sum_ff;

endmodule

// File: hdl/prime_sum_up_to_limit_unit.sv
`timescale 1ns / 1ps

// Sum of all primes from 2 up to req_limit, saturated at the top of rsp_prime_sum.
// A sieve runs in a one-bit-per-number RAM: composites are marked for each prime
// p with p*p <= limit, then one pass over 2..limit adds the unmarked entries and
// clears each entry behind it. After reset the RAM is cleared first, one entry a
// cycle, before the first request is taken. The marking and summing passes of a
// request are bound by the single write port of the RAM. One request is worked at
// a time; the result register lets the next request start while a result waits.
module prime_sum_up_to_limit_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  psum_pkg::addr_type   req_limit,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output psum_pkg::sum_type    rsp_prime_sum
);

   psum_pkg::mem_req_type mem_req;
   psum_pkg::status_type  status;
   logic                  rdata;
   logic                  take;
   logic                  rsp_valid_ff, rsp_valid_in;
   psum_pkg::sum_type     rsp_sum_ff, rsp_sum_in;

   assign req_stall = !status.idle;
   assign take      = status.done && (!rsp_valid_ff || !rsp_stall);

   psum_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (req_valid && status.idle),
      .limit   (req_limit),
      .take    (take),
      .rdata   (rdata),
      .mem_req (mem_req),
      .status  (status)
   );

   psum_ram #(
      .WIDTH (1),
      .DEPTH (psum_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = status.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_prime_sum = rsp_sum_ff;

endmodule

// File: hdl/psum_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psum_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input psum_pkg::sum_type  rsp_prime_sum
);

   // held result stays put
   `PSUM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `PSUM_ASSERT(a_rsp_data_hold, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_prime_sum))

   // an accepted request keeps the input side busy
   `PSUM_ASSERT(a_busy_after_req, clock, reset, req_valid && !req_stall |=> req_stall)

   // a new result only comes out of a busy engine
   `PSUM_ASSERT(a_rsp_from_busy, clock, reset, $rose(rsp_valid) |-> $past(req_stall))

   // nothing is accepted and no result shows during reset
   `PSUM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && req_stall)

endmodule

bind prime_sum_up_to_limit_unit psum_checker u_psum_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_prime_sum (rsp_prime_sum)
);
